### src/vmm_pkg.sv
package vmm_pkg;

   localparam int COORD_W = 16;
   localparam int MAG_W = 16;
   localparam int COUNT_W = 16;
   localparam int RAD_W = 2 * COORD_W;
   localparam int REM_W = MAG_W + 2;
   localparam int STEP_W = $clog2(MAG_W);

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam int ROW_LOG = 5;
   localparam int ROW_W = 1 << ROW_LOG;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

endpackage

### src/vmm_isqrt.sv
module vmm_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vmm_pkg::RAD_W-1:0]   radicand,
   output logic                        done,
   output logic [vmm_pkg::MAG_W-1:0]   root
);

   import vmm_pkg::*;

   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [MAG_W-1:0]  root_ff;
   logic [STEP_W-1:0] step_ff;
   logic              run_ff;
   logic              done_ff;
   logic [REM_W-1:0]  rem_sh_in;
   logic [REM_W-1:0]  trial_in;

   always_comb begin
      rem_sh_in = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial_in = {root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rad_ff <= radicand;
            rem_ff <= '0;
            root_ff <= '0;
            step_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            rad_ff <= rad_ff << 2;
            if (rem_sh_in >= trial_in) begin
               rem_ff <= rem_sh_in - trial_in;
               root_ff <= {root_ff[MAG_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh_in;
               root_ff <= {root_ff[MAG_W-2:0], 1'b0};
            end
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(MAG_W - 1)) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### src/vector_magnitude_match_counter_core.sv
// Loads a signed 2D vector or queries a magnitude; each accepted word returns exactly one
// result word, shown for one cycle under rsp_valid, and the receiver cannot stall it. After
// reset the block is busy while it clears the presence map, 2^(MAG_BITS-5) rows (2048 by
// default), one 32-bit row per cycle. A new word is taken only when busy is low. A query
// passes through the lookup and update states; a load first squares the coordinates, then
// starts and waits on the square-root unit, which retires one root bit per cycle for 16
// bits, and then reads and writes back the map row.
module vector_magnitude_match_counter_core #(
   parameter int MAG_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_cmd,
   input  logic signed [vmm_pkg::COORD_W-1:0] req_x_coord,
   input  logic signed [vmm_pkg::COORD_W-1:0] req_y_coord,
   input  logic [vmm_pkg::MAG_W-1:0]          req_query_magnitude,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic [vmm_pkg::COUNT_W-1:0]        rsp_match_count,
   output logic [vmm_pkg::MAG_W-1:0]          rsp_load_magnitude
);

   import vmm_pkg::*;

   localparam int ROW_AW = MAG_BITS - ROW_LOG;
   localparam int ROWS = 1 << ROW_AW;
   localparam int KEY_W = (MAG_BITS > MAG_W) ? MAG_BITS : MAG_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SQUARE,
      ST_ROOTGO,
      ST_ROOT,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   state_type           state_ff;
   logic [ROW_AW-1:0]   clr_addr_ff;
   logic                is_load_ff;
   logic [COORD_W-1:0]  ax_ff;
   logic [COORD_W-1:0]  ay_ff;
   logic [RAD_W-1:0]    sq_x_ff;
   logic [RAD_W-1:0]    sq_y_ff;
   logic [MAG_W-1:0]    key_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [ROW_W-1:0]    rd_row_ff;
   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [MAG_W-1:0]    rsp_mag_ff;

   logic [ROW_W-1:0]    map_mem [ROWS];

   logic [COORD_W-1:0]  ax_in;
   logic [COORD_W-1:0]  ay_in;
   logic [KEY_W-1:0]    key_wide;
   logic [ROW_AW-1:0]   key_row;
   logic [ROW_LOG-1:0]  key_bit;
   logic                in_range;
   logic [ROW_W-1:0]    bit_mask;
   logic                hit;
   logic                map_we;
   logic [ROW_AW-1:0]   map_waddr;
   logic [ROW_W-1:0]    map_wdata;
   logic                isqrt_start;
   logic [RAD_W-1:0]    isqrt_radicand;
   logic                isqrt_done;
   logic [MAG_W-1:0]    isqrt_root;
   logic [COUNT_W-1:0]  count_in;

   always_comb begin
      ax_in = req_x_coord[COORD_W-1] ? COORD_W'(-req_x_coord) : COORD_W'(req_x_coord);
      ay_in = req_y_coord[COORD_W-1] ? COORD_W'(-req_y_coord) : COORD_W'(req_y_coord);
      key_wide = KEY_W'(key_ff);
      key_row = key_wide[MAG_BITS-1:ROW_LOG];
      key_bit = key_wide[ROW_LOG-1:0];
      in_range = (key_wide >> MAG_BITS) == '0;
      bit_mask = ROW_W'(1) << key_bit;
      hit = in_range && rd_row_ff[key_bit];
      count_in = (hit && count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;
      isqrt_start = (state_ff == ST_ROOTGO);
      isqrt_radicand = RAD_W'(sq_x_ff + sq_y_ff);
      map_we = (state_ff == ST_CLEAR) ||
               (state_ff == ST_UPDATE && is_load_ff && in_range);
      map_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : key_row;
      map_wdata = (state_ff == ST_CLEAR) ? '0 : (rd_row_ff | bit_mask);
   end

   vmm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (isqrt_start),
      .radicand (isqrt_radicand),
      .done     (isqrt_done),
      .root     (isqrt_root)
   );

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      rd_row_ff <= map_mem[key_row];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_addr_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  is_load_ff <= (req_cmd == CMD_LOAD);
                  ax_ff <= ax_in;
                  ay_ff <= ay_in;
                  key_ff <= req_query_magnitude;
                  state_ff <= (req_cmd == CMD_LOAD) ? ST_SQUARE : ST_LOOKUP;
               end
            end
            ST_SQUARE: begin
               sq_x_ff <= RAD_W'(ax_ff * ax_ff);
               sq_y_ff <= RAD_W'(ay_ff * ay_ff);
               state_ff <= ST_ROOTGO;
            end
            ST_ROOTGO: begin
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (isqrt_done) begin
                  key_ff <= isqrt_root;
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               rsp_valid_ff <= 1'b1;
               if (is_load_ff) begin
                  rsp_found_ff <= 1'b0;
                  rsp_count_ff <= count_ff;
                  rsp_mag_ff <= key_ff;
               end else begin
                  rsp_found_ff <= hit;
                  rsp_count_ff <= count_in;
                  rsp_mag_ff <= '0;
                  count_ff <= count_in;
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_match_count = rsp_count_ff;
   assign rsp_load_magnitude = rsp_mag_ff;

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("Accepted word did not make the block busy.");

   a_root_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      isqrt_done |-> state_ff == ST_ROOT)
      else $error("Square-root unit finished outside the root wait state.");

   a_found_has_no_magnitude: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_load_magnitude == '0)
      else $error("Query match reported a load magnitude.");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_CLEAR |=> count_ff >= $past(count_ff))
      else $error("Match count decreased.");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import vmm_pkg::*;

   localparam int MAP_BITS = 16;
   localparam longint MAP_DEPTH = longint'(1) << MAP_BITS;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic                      cmd;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [MAG_W-1:0]          qmag;
      int                        gap_max;
   } vec_word_type;

   typedef struct {
      logic               found;
      logic [COUNT_W-1:0] count;
      logic [MAG_W-1:0]   mag;
   } result_word_type;

   logic                      clock;
   logic                      reset;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_cmd = CMD_LOAD;
   logic signed [COORD_W-1:0] req_x_coord = '0;
   logic signed [COORD_W-1:0] req_y_coord = '0;
   logic [MAG_W-1:0]          req_query_magnitude = '0;
   logic                      rsp_valid;
   logic                      rsp_found;
   logic [COUNT_W-1:0]        rsp_match_count;
   logic [MAG_W-1:0]          rsp_load_magnitude;

   vec_word_type    words_to_send[$];
   result_word_type result_words_due[$];
   vec_word_type    word_on_bus;
   result_word_type due_word;

   bit                 magnitude_present [0:MAP_DEPTH-1];
   logic [COUNT_W-1:0] matching_queries = '0;
   int                 loads_seen = 0;
   int                 queries_seen = 0;
   int                 hits_seen = 0;

   int words_total = 0;
   int words_accepted = 0;
   int burst_left = 0;
   int idle_left = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int loaded_mags[$];

   vector_magnitude_match_counter_core #(
      .MAG_BITS(MAP_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_x_coord(req_x_coord),
      .req_y_coord(req_y_coord),
      .req_query_magnitude(req_query_magnitude),
      .rsp_valid(rsp_valid),
      .rsp_found(rsp_found),
      .rsp_match_count(rsp_match_count),
      .rsp_load_magnitude(rsp_load_magnitude)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic logic [MAG_W-1:0] root_floor(longint unsigned n);
      logic [MAG_W-1:0] r;
      logic [MAG_W-1:0] trial;
      longint unsigned  t;
      r = '0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
         trial = r | (MAG_W'(1) << b);
         t = trial;
         if (t * t <= n) begin
            r = trial;
         end
      end
      return r;
   endfunction

   function automatic result_word_type lookup_or_record(vec_word_type w);
      result_word_type r;
      longint          xs;
      longint          ys;
      r.found = 1'b0;
      r.mag = '0;
      if (w.cmd == CMD_LOAD) begin
         xs = w.x;
         ys = w.y;
         r.mag = root_floor(xs * xs + ys * ys);
         if (longint'(r.mag) < MAP_DEPTH) begin
            magnitude_present[r.mag] = 1'b1;
         end
         loads_seen++;
      end else begin
         queries_seen++;
         if (longint'(w.qmag) < MAP_DEPTH && magnitude_present[w.qmag]) begin
            r.found = 1'b1;
            hits_seen++;
            if (matching_queries != COUNT_MAX) begin
               matching_queries = matching_queries + 1'b1;
            end
         end
      end
      r.count = matching_queries;
      return r;
   endfunction

   task automatic push_load(int x, int y, int gap_max);
      vec_word_type w;
      longint       xs;
      longint       ys;
      w.cmd = CMD_LOAD;
      w.x = COORD_W'(x);
      w.y = COORD_W'(y);
      w.qmag = MAG_W'($urandom);
      w.gap_max = gap_max;
      words_to_send.insert(words_to_send.size(), w);
      xs = w.x;
      ys = w.y;
      loaded_mags.insert(loaded_mags.size(), int'(root_floor(xs * xs + ys * ys)));
   endtask

   task automatic push_query(int q, int gap_max);
      vec_word_type w;
      w.cmd = CMD_QUERY;
      w.x = COORD_W'($urandom);
      w.y = COORD_W'($urandom);
      w.qmag = MAG_W'(q);
      w.gap_max = gap_max;
      words_to_send.insert(words_to_send.size(), w);
   endtask

   function automatic int pick_coord();
      int mode;
      int corner_vals[5];
      corner_vals = '{-32768, -32767, 32767, 0, -1};
      mode = $urandom_range(0, 99);
      if (mode < 60) begin
         return int'($urandom_range(0, 65535)) - 32768;
      end else if (mode < 85) begin
         return int'($urandom_range(0, 128)) - 64;
      end
      return corner_vals[$urandom_range(0, 4)];
   endfunction

   function automatic int pick_query();
      int mode;
      int q;
      mode = $urandom_range(0, 99);
      if (loaded_mags.size() == 0 || mode >= 70) begin
         return $urandom_range(0, 65535);
      end
      q = loaded_mags[$urandom_range(0, loaded_mags.size() - 1)];
      if (mode >= 55) begin
         q = ($urandom_range(0, 1) == 1) ? q + 1 : q - 1;
         if (q < 0) begin
            q = 0;
         end
      end
      return q;
   endfunction

   function automatic int pick_gap();
      int mode;
      mode = $urandom_range(0, 99);
      if (mode < 20) begin
         return 0;
      end else if (mode < 75) begin
         return 4;
      end
      return 25;
   endfunction

   task automatic push_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 40) begin
            push_load(pick_coord(), pick_coord(), pick_gap());
         end else begin
            push_query(pick_query(), pick_gap());
         end
      end
   endtask

   // The sender works in bursts; a word stays on the bus until busy is low at an edge.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            result_words_due.insert(result_words_due.size(), lookup_or_record(word_on_bus));
            words_accepted++;
         end
         if (start && busy) begin
            start <= 1'b1;
         end else if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (words_to_send.size() > 0) begin
            word_on_bus = words_to_send.pop_front();
            req_cmd <= word_on_bus.cmd;
            req_x_coord <= word_on_bus.x;
            req_y_coord <= word_on_bus.y;
            req_query_magnitude <= word_on_bus.qmag;
            start <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 12);
               idle_left = $urandom_range(0, word_on_bus.gap_max);
            end else begin
               burst_left--;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (result_words_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result word: found=%0d count=%0d mag=%0d",
                        rsp_found, rsp_match_count, rsp_load_magnitude);
            end
         end else begin
            due_word = result_words_due.pop_front();
            if (rsp_found !== due_word.found || rsp_match_count !== due_word.count ||
                rsp_load_magnitude !== due_word.mag) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected found=%0d count=%0d mag=%0d, ",
                           due_word.found, due_word.count, due_word.mag,
                           "got found=%0d count=%0d mag=%0d",
                           rsp_found, rsp_match_count, rsp_load_magnitude);
               end
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timed out after %0d cycles", cycle_count);
      $display("[vector_magnitude_match_counter_core] ERROR");
      $finish;
   end

   initial begin
      reset = 1'b1;

      // Queries against a freshly cleared map must miss.
      push_query(0, 0);
      push_query(65535, 0);
      push_load(0, 0, 0);
      push_query(0, 3);
      push_load(-32768, -32768, 0);
      push_load(32767, 32767, 25);
      push_load(-32768, 0, 1);
      push_load(32767, -32768, 0);
      push_load(0, -32767, 0);
      push_load(3, -4, 2);
      push_load(-1, 1, 0);
      push_load(2, 3, 0);
      push_query(46340, 0);
      push_query(46339, 0);
      push_query(32768, 5);
      push_query(32767, 0);
      push_query(5, 0);
      push_query(5, 0);
      push_query(4, 0);
      push_query(46341, 0);
      push_query(65535, 0);
      push_query(1, 0);
      push_query(3, 0);
      push_random(607);
      push_random(20);
      words_total = words_to_send.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (words_accepted < words_total || result_words_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d loads and %0d queries; %0d queries found their magnitude.",
               loads_seen, queries_seen, hits_seen);
      $display("The match count ended at %0d after %0d cycles, with %0d mismatches.",
               matching_queries, cycle_count, mismatch_count);
      if (mismatch_count == 0 && result_words_due.size() == 0) begin
         $display("[vector_magnitude_match_counter_core] OK");
      end else begin
         $display("[vector_magnitude_match_counter_core] ERROR");
      end
      $finish;
   end

endmodule

### vector_magnitude_match_counter_core.f
src/vmm_pkg.sv
src/vmm_isqrt.sv
src/vector_magnitude_match_counter_core.sv
tb/tb_top.sv
